// ===== src/mhtq_pkg.sv =====
// Package for the min-heap timer queue: constants, opcode and kind codes,
// controller state type. No dependencies.
`default_nettype none
package mhtq_pkg;
   localparam int HEAP_DEPTH_DEF   = 32;
   localparam int HANDLE_COUNT_DEF = 64;
   localparam int TIME_W   = 32;
   localparam int HANDLE_W = 6;
   localparam int OP_W     = 2;
   localparam int KIND_W   = 3;

   localparam logic [OP_W-1:0] OP_ADD    = 2'd0;
   localparam logic [OP_W-1:0] OP_CANCEL = 2'd1;
   localparam logic [OP_W-1:0] OP_TICK   = 2'd2;
   // Not assigned to any operation; the block ignores it.
   localparam logic [OP_W-1:0] OP_SPARE  = 2'd3;

   localparam logic [KIND_W-1:0] KIND_FIRED    = 3'd0;
   localparam logic [KIND_W-1:0] KIND_ADD_OK   = 3'd1;
   localparam logic [KIND_W-1:0] KIND_ADD_FULL = 3'd2;
   localparam logic [KIND_W-1:0] KIND_CANCEL   = 3'd3;
   localparam logic [KIND_W-1:0] KIND_DONE     = 3'd4;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_UP_RD,
      ST_UP_CMP,
      ST_TK_RD,
      ST_TK_CHK,
      ST_POP_RD,
      ST_POP_LAST,
      ST_DN_RD,
      ST_DN_CMP,
      ST_OUT
   } state_type;
endpackage
`default_nettype wire

// ===== src/mhtq_if.sv =====
// Valid/ready channel interfaces for requests and responses.
// Depends on mhtq_pkg.
`default_nettype none
interface mhtq_req_if import mhtq_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [OP_W-1:0]     opcode;
   logic [TIME_W-1:0]   expire_time;
   logic [HANDLE_W-1:0] handle;
   logic [TIME_W-1:0]   now;
   modport source (output valid, opcode, expire_time, handle, now, input ready);
   modport sink   (input valid, opcode, expire_time, handle, now, output ready);
endinterface

interface mhtq_rsp_if import mhtq_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [KIND_W-1:0]   kind;
   logic [HANDLE_W-1:0] fired_handle;
   logic                last;
   modport source (output valid, kind, fired_handle, last, input ready);
   modport sink   (input valid, kind, fired_handle, last, output ready);
endinterface
`default_nettype wire

// ===== src/mhtq_heap_ram.sv =====
// Heap slot memory: expiry and owner, one write and two read ports,
// registered reads. Depends on mhtq_pkg.
`default_nettype none
module mhtq_heap_ram import mhtq_pkg::*; #(
   parameter int HEAP_DEPTH = HEAP_DEPTH_DEF,
   localparam int AW = $clog2(HEAP_DEPTH)
) (
   input  wire logic                clock,
   input  wire logic                we,
   input  wire logic [AW-1:0]       waddr,
   input  wire logic [TIME_W-1:0]   wexp,
   input  wire logic [HANDLE_W-1:0] wown,
   input  wire logic [AW-1:0]       raddr_a,
   input  wire logic [AW-1:0]       raddr_b,
   output logic      [TIME_W-1:0]   rexp_a,
   output logic      [HANDLE_W-1:0] rown_a,
   output logic      [TIME_W-1:0]   rexp_b,
   output logic      [HANDLE_W-1:0] rown_b
);
   logic [TIME_W+HANDLE_W-1:0] mem [HEAP_DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= {wexp, wown};
      end
      {rexp_a, rown_a} <= mem[raddr_a];
      {rexp_b, rown_b} <= mem[raddr_b];
   end
endmodule
`default_nettype wire

// ===== src/min_heap_timer_queue_top.sv =====
// Top level of the min-heap timer queue: controller, live marks, heap memory.
// Depends on mhtq_pkg, mhtq_if and mhtq_heap_ram.
`default_nettype none
// Steps from accepting a request to its response: cancel and a rejected add
// answer from idle; an add into an empty heap goes straight to the output
// step, else it reads and compares the parent for each level on the way up.
// A tick reads and checks the root; per popped entry it reads the last slot,
// then reads and compares the children for each level the hole moves down and
// ends in the output step, or rechecks the root when the pop empties the heap.
// A fired response does not hold up the tick unless the response channel
// stalls. One request is taken at a time, only while idle. Synchronous reset
// clears the count, live marks and controller; heap slots are left unwritten.
module min_heap_timer_queue_top import mhtq_pkg::*; #(
   parameter int HEAP_DEPTH   = HEAP_DEPTH_DEF,
   parameter int HANDLE_COUNT = HANDLE_COUNT_DEF
) (
   input wire logic clock,
   input wire logic reset,
   mhtq_req_if.sink   req,
   mhtq_rsp_if.source rsp
);
   localparam int AW = $clog2(HEAP_DEPTH);
   localparam int CW = $clog2(HEAP_DEPTH + 1);
   localparam int HW = $clog2(HANDLE_COUNT);

   state_type state_ff, state_in;
   logic [CW-1:0]       count_ff, count_in;
   logic [CW-1:0]       hole_ff, hole_in;
   logic [TIME_W-1:0]   key_ff, key_in;
   logic [HANDLE_W-1:0] own_ff, own_in;
   logic [TIME_W-1:0]   now_ff, now_in;
   logic                tick_ff, tick_in;
   logic [HANDLE_COUNT-1:0] live_ff, live_in;
   logic                ovalid_ff, ovalid_in;
   logic [KIND_W-1:0]   okind_ff, okind_in;
   logic [HANDLE_W-1:0] ohandle_ff, ohandle_in;
   logic                olast_ff, olast_in;

   logic                we;
   logic [AW-1:0]       waddr, ra, rb;
   logic [TIME_W-1:0]   wexp, rexp_a, rexp_b;
   logic [HANDLE_W-1:0] wown, rown_a, rown_b;

   mhtq_heap_ram #(.HEAP_DEPTH(HEAP_DEPTH)) u_ram (
      .clock, .we, .waddr, .wexp, .wown,
      .raddr_a(ra), .raddr_b(rb),
      .rexp_a, .rown_a, .rexp_b, .rown_b
   );

   // Index helpers, widened so that 2*hole+2 never wraps.
   logic [CW:0] left_w, right_w, parent_w;
   assign left_w   = {hole_ff, 1'b1};
   assign right_w  = {hole_ff, 1'b0} + (CW+1)'(2);
   assign parent_w = ({1'b0, hole_ff} - (CW+1)'(1)) >> 1;

   // Live mark of the entry at the heap root, read while a tick checks it.
   logic handle_live;
   assign handle_live = (HW >= HANDLE_W || rown_a < HANDLE_W'(HANDLE_COUNT))
                        && live_ff[HW'(rown_a)];

   logic rsp_free;
   assign rsp_free = !ovalid_ff || rsp.ready;
   assign req.ready = (state_ff == ST_IDLE) && rsp_free;
   assign rsp.valid = ovalid_ff;
   assign rsp.kind = okind_ff;
   assign rsp.fired_handle = ohandle_ff;
   assign rsp.last = olast_ff;

   logic req_fire;
   assign req_fire = req.valid && req.ready;

   // Child selection for the sift-down: the right child wins only when it
   // exists and is strictly smaller than the left one.
   logic right_ok, pick_right;
   logic [TIME_W-1:0]   c_exp;
   logic [HANDLE_W-1:0] c_own;
   always_comb begin
      right_ok   = right_w < {1'b0, count_ff};
      pick_right = right_ok && (rexp_a > rexp_b);
      c_exp = pick_right ? rexp_b : rexp_a;
      c_own = pick_right ? rown_b : rown_a;
   end

   // Next-state logic.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               if (req.opcode == OP_ADD && count_ff != CW'(HEAP_DEPTH)) begin
                  state_in = (count_ff == '0) ? ST_OUT : ST_UP_RD;
               end else if (req.opcode == OP_TICK) begin
                  state_in = ST_TK_RD;
               end
            end
         end
         ST_UP_RD:  state_in = ST_UP_CMP;
         ST_UP_CMP: begin
            if (rexp_a <= key_ff || parent_w == '0) state_in = ST_OUT;
            else state_in = ST_UP_RD;
         end
         ST_TK_RD:  state_in = ST_TK_CHK;
         ST_TK_CHK: begin
            if (count_ff != '0 && rexp_a <= now_ff) begin
               if (!handle_live || rsp_free) state_in = ST_POP_RD;
            end else if (rsp_free) begin
               state_in = ST_IDLE;
            end
         end
         ST_POP_RD:   state_in = ST_POP_LAST;
         ST_POP_LAST: state_in = (count_ff == '0) ? ST_TK_RD : ST_DN_RD;
         ST_DN_RD: begin
            // No left child: the moved entry lands at the hole.
            if (left_w >= {1'b0, count_ff}) state_in = ST_OUT;
            else state_in = ST_DN_CMP;
         end
         ST_DN_CMP: begin
            // A child strictly greater than the moved entry stops the descent.
            if (c_exp <= key_ff) state_in = ST_DN_RD;
            else state_in = ST_OUT;
         end
         ST_OUT: begin
            if (rsp_free) state_in = tick_ff ? ST_TK_RD : ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Datapath and output logic.
   always_comb begin
      count_in = count_ff; hole_in = hole_ff; key_in = key_ff; own_in = own_ff;
      now_in = now_ff; tick_in = tick_ff; live_in = live_ff;
      ovalid_in = ovalid_ff && !rsp.ready;
      okind_in = okind_ff; ohandle_in = ohandle_ff; olast_in = olast_ff;
      we = 1'b0; waddr = '0; wexp = key_ff; wown = own_ff;
      ra = '0; rb = '0;
      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               key_in = req.expire_time; own_in = req.handle; now_in = req.now;
               hole_in = count_ff; tick_in = 1'b0;
               okind_in = KIND_ADD_OK; ohandle_in = req.handle; olast_in = 1'b1;
               case (req.opcode)
                  OP_ADD: begin
                     if (count_ff == CW'(HEAP_DEPTH)) begin
                        okind_in = KIND_ADD_FULL; ovalid_in = 1'b1;
                     end else begin
                        count_in = count_ff + CW'(1);
                        if (HW >= HANDLE_W || req.handle < HANDLE_W'(HANDLE_COUNT))
                           live_in[HW'(req.handle)] = 1'b1;
                     end
                  end
                  OP_CANCEL: begin
                     okind_in = KIND_CANCEL; ovalid_in = 1'b1;
                     if (HW >= HANDLE_W || req.handle < HANDLE_W'(HANDLE_COUNT))
                        live_in[HW'(req.handle)] = 1'b0;
                  end
                  OP_TICK: tick_in = 1'b1;
                  default: ;
               endcase
            end
         end
         ST_UP_RD: ra = AW'(parent_w);
         ST_UP_CMP: begin
            if (rexp_a > key_ff) begin
               we = 1'b1; waddr = AW'(hole_ff); wexp = rexp_a; wown = rown_a;
               hole_in = CW'(parent_w);
            end
         end
         ST_TK_RD: ra = '0;
         ST_TK_CHK: begin
            if (count_ff != '0 && rexp_a <= now_ff) begin
               if (handle_live && rsp_free) begin
                  ovalid_in = 1'b1; okind_in = KIND_FIRED;
                  ohandle_in = rown_a; olast_in = 1'b0;
               end
            end else if (rsp_free) begin
               ovalid_in = 1'b1; okind_in = KIND_DONE;
               ohandle_in = '0; olast_in = 1'b1;
            end
         end
         ST_POP_RD: begin
            count_in = count_ff - CW'(1);
            ra = AW'(count_ff - CW'(1));
            hole_in = '0;
         end
         ST_POP_LAST: begin
            key_in = rexp_a; own_in = rown_a;
         end
         ST_DN_RD: begin
            ra = AW'(left_w); rb = AW'(right_w);
         end
         ST_DN_CMP: begin
            if (c_exp <= key_ff) begin
               we = 1'b1; waddr = AW'(hole_ff); wexp = c_exp; wown = c_own;
               hole_in = pick_right ? CW'(right_w) : CW'(left_w);
            end
         end
         ST_OUT: begin
            if (rsp_free) begin
               we = 1'b1; waddr = AW'(hole_ff);
               if (!tick_ff) ovalid_in = 1'b1;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE; count_ff <= '0; live_ff <= '0;
         ovalid_ff <= 1'b0; tick_ff <= 1'b0;
      end else begin
         state_ff <= state_in; count_ff <= count_in; live_ff <= live_in;
         ovalid_ff <= ovalid_in; tick_ff <= tick_in;
      end
      hole_ff <= hole_in; key_ff <= key_in; own_ff <= own_in; now_ff <= now_in;
      okind_ff <= okind_in; ohandle_ff <= ohandle_in; olast_ff <= olast_in;
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(HEAP_DEPTH)) else $error("entry count above depth");
   a_idle_only_accept: assert property (@(posedge clock) disable iff (reset)
      req.ready |-> state_ff == ST_IDLE) else $error("accept outside idle");
   a_out_hold: assert property (@(posedge clock) disable iff (reset)
      rsp.valid && !rsp.ready |=> rsp.valid && $stable(rsp.kind))
      else $error("response dropped");
endmodule
`default_nettype wire
